[rtl/efi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_pkg
// Shared types, codes and constants of the escape-time fractal iterator.
// ----------------------------------------------------------------------------
package efi_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FRACTAL_MODE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_ITERATIONS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_JULIA_C_RE     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_JULIA_C_IM     = 2'd3;

   localparam logic [1:0] MODE_MANDELBROT = 2'd0;
   localparam logic [1:0] MODE_TRICORN    = 2'd1;
   localparam logic [1:0] MODE_SHIP       = 2'd2;
   localparam logic [1:0] MODE_JULIA      = 2'd3;

   localparam logic [15:0] MAX_ITER_RESET = 16'd100;

   localparam logic [63:0] JDEF_RE_NUM = 64'd766667;
   localparam logic [63:0] JDEF_IM_NUM = 64'd90000;
   localparam logic [63:0] JDEF_DEN    = 64'd1000000;

   typedef struct packed {
      logic [1:0]         mode;
      logic [15:0]        max_iter;
      logic signed [31:0] julia_re;
      logic signed [31:0] julia_im;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MULT,
      ST_UPDATE,
      ST_SQUARE,
      ST_TEST,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic mult;
      logic update;
      logic square;
      logic advance;
      logic mark_escape;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic start_stop;
      logic escape;
      logic last;
   } status_type;

   // negative default Julia part, truncated toward zero to frac fraction bits
   function automatic logic [31:0] jdef(input logic [63:0] num, input int frac);
      logic [63:0] mag;
      mag = (num << frac) / JDEF_DEN;
      return 32'(-mag);
   endfunction

endpackage

[rtl/efi_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_req_if
// Input item channel: pixel point, start z and start count.
// ----------------------------------------------------------------------------
interface efi_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] c_re;
   logic signed [31:0] c_im;
   logic signed [31:0] z_re_start;
   logic signed [31:0] z_im_start;
   logic [15:0]        start_count;

   modport source (output valid, c_re, c_im, z_re_start, z_im_start, start_count,
                   input ready);
   modport sink   (input valid, c_re, c_im, z_re_start, z_im_start, start_count,
                   output ready);
endinterface

[rtl/efi_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_rsp_if
// Result item channel: final count, escape flag and final z.
// ----------------------------------------------------------------------------
interface efi_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        iterations;
   logic               escaped;
   logic signed [31:0] z_re_final;
   logic signed [31:0] z_im_final;

   modport source (output valid, iterations, escaped, z_re_final, z_im_final,
                   input ready);
   modport sink   (input valid, iterations, escaped, z_re_final, z_im_final,
                   output ready);
endinterface

[rtl/escape_time_fractal_iterator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_core
// Each iteration steps through prepare, multiply, update/saturate, square
// and test, all on one shared datapath. An item whose start_count is at or
// above the limit goes straight to the result without iterating.
// Throughput: one item at a time; the next item is taken while a result
// waits in the output register.
// Reset: synchronous, active high; sequencer idle, no result pending,
// configuration registers at their reset values.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator_core #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 28
) (
   input  logic                               clock,
   input  logic                               reset,
   efi_req_if.sink                            req_chan,
   efi_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [efi_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [efi_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   efi_pkg::cfg_type    cfg;
   efi_pkg::cmd_type    cmd;
   efi_pkg::status_type status;

   efi_regs #(
      .FRAC_BITS (FRAC_BITS)
   ) u_regs (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_wr_en),
      .index   (csr_index),
      .wr_data (csr_wr_data),
      .cfg     (cfg)
   );

   efi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   efi_datapath #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg),
      .in_c_re        (req_chan.c_re),
      .in_c_im        (req_chan.c_im),
      .in_z_re        (req_chan.z_re_start),
      .in_z_im        (req_chan.z_im_start),
      .in_start_count (req_chan.start_count),
      .status         (status),
      .out_iterations (rsp_chan.iterations),
      .out_escaped    (rsp_chan.escaped),
      .out_z_re       (rsp_chan.z_re_final),
      .out_z_im       (rsp_chan.z_im_final)
   );

endmodule

[rtl/efi_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_regs
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module efi_regs #(
   parameter int FRAC_BITS = 28
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic [efi_pkg::CSR_INDEX_BITS-1:0]    index,
   input  logic [efi_pkg::CSR_DATA_BITS-1:0]     wr_data,
   output efi_pkg::cfg_type                      cfg
);

   localparam logic [31:0] JDEF_RE = efi_pkg::jdef(efi_pkg::JDEF_RE_NUM, FRAC_BITS);
   localparam logic [31:0] JDEF_IM = efi_pkg::jdef(efi_pkg::JDEF_IM_NUM, FRAC_BITS);

   efi_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            efi_pkg::REG_FRACTAL_MODE:   cfg_in.mode     = wr_data[1:0];
            efi_pkg::REG_MAX_ITERATIONS: cfg_in.max_iter = wr_data[15:0];
            efi_pkg::REG_JULIA_C_RE:     cfg_in.julia_re = wr_data;
            efi_pkg::REG_JULIA_C_IM:     cfg_in.julia_im = wr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode     <= efi_pkg::MODE_MANDELBROT;
         cfg_ff.max_iter <= efi_pkg::MAX_ITER_RESET;
         cfg_ff.julia_re <= JDEF_RE;
         cfg_ff.julia_im <= JDEF_IM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/efi_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_ctrl
// Sequencer: steps each iteration through prepare, multiply, update,
// square and test, and hands finished items to the output register.
// ----------------------------------------------------------------------------
module efi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  efi_pkg::status_type  status,
   output efi_pkg::cmd_type     cmd
);

   efi_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         efi_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.start_stop ? efi_pkg::ST_FINISH : efi_pkg::ST_PREP;
            end
         end
         efi_pkg::ST_PREP:   state_in = efi_pkg::ST_MULT;
         efi_pkg::ST_MULT:   state_in = efi_pkg::ST_UPDATE;
         efi_pkg::ST_UPDATE: state_in = efi_pkg::ST_SQUARE;
         efi_pkg::ST_SQUARE: state_in = efi_pkg::ST_TEST;
         efi_pkg::ST_TEST: begin
            if (status.escape || status.last) begin
               state_in = efi_pkg::ST_FINISH;
            end else begin
               state_in = efi_pkg::ST_PREP;
            end
         end
         efi_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = efi_pkg::ST_IDLE;
            end
         end
         default: state_in = efi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         efi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         efi_pkg::ST_PREP:   cmd.prep   = 1'b1;
         efi_pkg::ST_MULT:   cmd.mult   = 1'b1;
         efi_pkg::ST_UPDATE: cmd.update = 1'b1;
         efi_pkg::ST_SQUARE: cmd.square = 1'b1;
         efi_pkg::ST_TEST: begin
            cmd.mark_escape = status.escape;
            cmd.advance     = !status.escape;
         end
         efi_pkg::ST_FINISH: cmd.out_load = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= efi_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/efi_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_datapath
// Fixed-point complex square step, saturation, magnitude test, iteration
// counter and output register.
// ----------------------------------------------------------------------------
module efi_datapath #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 28
) (
   input  logic                 clock,
   input  logic                 reset,
   input  efi_pkg::cmd_type     cmd,
   input  efi_pkg::cfg_type     cfg,
   input  logic signed [31:0]   in_c_re,
   input  logic signed [31:0]   in_c_im,
   input  logic signed [31:0]   in_z_re,
   input  logic signed [31:0]   in_z_im,
   input  logic [15:0]          in_start_count,
   output efi_pkg::status_type  status,
   output logic [15:0]          out_iterations,
   output logic                 out_escaped,
   output logic signed [31:0]   out_z_re,
   output logic signed [31:0]   out_z_im
);

   localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;
   localparam logic [31:0] JDEF_RE = efi_pkg::jdef(efi_pkg::JDEF_RE_NUM, FRAC_BITS);
   localparam logic [31:0] JDEF_IM = efi_pkg::jdef(efi_pkg::JDEF_IM_NUM, FRAC_BITS);
   localparam logic [63:0] FOUR    = 64'd1 << (2 * FRAC_BITS + 2);
   localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic signed [31:0] c_re_ff, c_im_ff, k_re_ff, k_im_ff, z_re_ff, z_im_ff;
   logic signed [32:0] xa_ff, ya_ff;
   logic signed [65:0] xx_ff, yy_ff, xy_ff;
   logic signed [63:0] sq_re_ff, sq_im_ff;
   logic [CW-1:0]      count_ff;
   logic               esc_ff;
   logic [15:0]        out_iter_ff;
   logic               out_esc_ff;
   logic signed [31:0] out_re_ff, out_im_ff;

   logic [CW-1:0]      limit, count_next;
   logic signed [31:0] k_re_in, k_im_in, x_sel, y_sel;
   logic signed [32:0] xa_in, ya_in;
   logic signed [65:0] diff, prod, re_sum, im_sum;
   logic [63:0]        mag;

   assign limit      = cfg.max_iter[CW-1:0];
   assign count_next = count_ff + CW'(1);

   always_comb begin
      k_re_in = in_c_re;
      k_im_in = in_c_im;
      if (cfg.mode == efi_pkg::MODE_JULIA) begin
         if (cfg.julia_re == 32'sd0) begin
            k_re_in = JDEF_RE;
            k_im_in = JDEF_IM;
         end else begin
            k_re_in = cfg.julia_re;
            k_im_in = cfg.julia_im;
         end
      end
   end

   always_comb begin
      x_sel = z_re_ff;
      y_sel = z_im_ff;
      if (cfg.mode == efi_pkg::MODE_JULIA && z_re_ff == 32'sd0) begin
         x_sel = c_re_ff;
         y_sel = c_im_ff;
      end
      xa_in = {x_sel[31], x_sel};
      ya_in = {y_sel[31], y_sel};
      if (cfg.mode == efi_pkg::MODE_SHIP) begin
         if (x_sel[31]) begin
            xa_in = -xa_in;
         end
         if (y_sel[31]) begin
            ya_in = -ya_in;
         end
      end
   end

   always_comb begin
      diff   = xx_ff - yy_ff;
      prod   = (cfg.mode == efi_pkg::MODE_TRICORN) ? -xy_ff : xy_ff;
      re_sum = (diff >>> FRAC_BITS) + 66'(k_re_ff);
      im_sum = (prod >>> (FRAC_BITS - 1)) + 66'(k_im_ff);
      mag    = 64'(sq_re_ff) + 64'(sq_im_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         c_re_ff  <= in_c_re;
         c_im_ff  <= in_c_im;
         k_re_ff  <= k_re_in;
         k_im_ff  <= k_im_in;
         z_re_ff  <= in_z_re;
         z_im_ff  <= in_z_im;
         count_ff <= in_start_count[CW-1:0];
      end
      if (cmd.prep) begin
         xa_ff <= xa_in;
         ya_ff <= ya_in;
      end
      if (cmd.mult) begin
         xx_ff <= xa_ff * xa_ff;
         yy_ff <= ya_ff * ya_ff;
         xy_ff <= xa_ff * ya_ff;
      end
      if (cmd.update) begin
         z_re_ff <= sat32(re_sum);
         z_im_ff <= sat32(im_sum);
      end
      if (cmd.square) begin
         sq_re_ff <= z_re_ff * z_re_ff;
         sq_im_ff <= z_im_ff * z_im_ff;
      end
      if (cmd.advance) begin
         count_ff <= count_next;
      end
      if (cmd.out_load) begin
         out_iter_ff <= 16'(count_ff);
         out_esc_ff  <= esc_ff;
         out_re_ff   <= z_re_ff;
         out_im_ff   <= z_im_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         esc_ff <= 1'b0;
      end else if (cmd.mark_escape) begin
         esc_ff <= 1'b1;
      end
   end

   assign status.start_stop = !(in_start_count[CW-1:0] < limit);
   assign status.escape     = mag >= FOUR;
   assign status.last       = count_next == limit;

   assign out_iterations = out_iter_ff;
   assign out_escaped    = out_esc_ff;
   assign out_z_re       = out_re_ff;
   assign out_z_im       = out_im_ff;

endmodule
